### design/rpls_pkg.sv
// ----------------------------------------------------------------------------
// rpls_pkg
// shared constants, sequencing codes and control bundles of the
// plate likeness scorer
// ----------------------------------------------------------------------------
`default_nettype none

package rpls_pkg;

    localparam int RPLS_MAX_BOX_SIDE  = 2048;
    localparam int RPLS_FRACTION_BITS = 12;

    localparam int CNT_W   = 23;
    localparam int SUM_W   = 30;
    localparam int SQSUM_W = 38;
    localparam int SIDE_W  = 12;
    localparam int FRAME_W = 13;

    // divisions done on the shared divider, in the order they are run
    typedef enum logic [2:0] {
        DIV_ASPECT,
        DIV_EDGE,
        DIV_WHITE,
        DIV_LD,
        DIV_CON
    } div_sel_t;

    typedef struct packed {
        logic     acc;
        logic     mul;
        logic     prep1;
        logic     prep2;
        logic     div_start;
        div_sel_t div_sel;
        logic     div_cap;
        logic     sqrt_start;
        logic     sqrt_cap;
        logic     sum;
        logic     load_out;
    } rpls_cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
    } rpls_status_t;

endpackage

`default_nettype wire

### design/rpls_div.sv
// ----------------------------------------------------------------------------
// rpls_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rpls_div #(
    parameter int NUM_W = 71,
    parameter int DEN_W = 46
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, quot_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                den_reg  <= den;
                quot_reg <= num;
                cnt_reg  <= CW'(NUM_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                quot_reg <= {quot_reg[NUM_W-2:0], ge};
                cnt_reg  <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

### design/rpls_sqrt.sv
// ----------------------------------------------------------------------------
// rpls_sqrt
// integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rpls_sqrt #(
    parameter int F = 12
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [2*F-1:0] x_in,
    output logic              done,
    output logic [F:0]        root
);

    localparam int XW = 2 * F;
    localparam int CW = $clog2(F + 1);

    logic [XW-1:0] x_reg;
    logic [XW-1:0] res_reg;
    logic [XW-1:0] bit_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [XW:0]   trial;
    logic          ge;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign ge    = {1'b0, x_reg} >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg    <= x_in;
                res_reg  <= '0;
                bit_reg  <= XW'(1) << (XW - 2);
                cnt_reg  <= CW'(F);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (ge) begin
                    x_reg   <= x_reg - trial[XW-1:0];
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[F:0];

endmodule

`default_nettype wire

### design/rpls_datapath.sv
// ----------------------------------------------------------------------------
// rpls_datapath
// per pixel accumulators, score term arithmetic and result register
// ----------------------------------------------------------------------------
`default_nettype none

module rpls_datapath #(
    parameter int MAX_BOX_SIDE  = rpls_pkg::RPLS_MAX_BOX_SIDE,
    parameter int FRACTION_BITS = rpls_pkg::RPLS_FRACTION_BITS
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire rpls_pkg::rpls_cmd_t      cmd,
    output rpls_pkg::rpls_status_t        status,
    input  wire logic [7:0]               edge_value,
    input  wire logic [7:0]               red,
    input  wire logic [7:0]               green,
    input  wire logic [7:0]               blue,
    input  wire logic [11:0]              box_width,
    input  wire logic [11:0]              box_height,
    input  wire logic [12:0]              frame_width,
    input  wire logic [12:0]              frame_height,
    output logic [15:0]                   total_score
);

    import rpls_pkg::*;

    localparam int F      = FRACTION_BITS;
    localparam int TERM_W = F + 1;
    localparam int K      = 2 * F - 14;
    localparam int NUM_W  = 47 + 2 * F;
    localparam int DEN_W  = 46;
    localparam int TOT_W  = (F + 5 > 17) ? F + 5 : 17;
    localparam logic [TERM_W-1:0] ONE_T = {1'b1, {F{1'b0}}};

    // box accumulators
    logic [CNT_W-1:0]   pix_cnt_reg, edge_cnt_reg, bright_cnt_reg, dark_cnt_reg;
    logic [CNT_W-1:0]   white_cnt_reg;
    logic [SUM_W-1:0]   gray_sum_reg;
    logic [SQSUM_W-1:0] gray_sq_reg;
    logic [SIDE_W-1:0]  held_w_reg, held_h_reg;

    // per pixel color math
    logic [21:0] gray_acc;
    logic [7:0]  gray;
    logic [7:0]  vmax, vmin, mx_rg, mn_rg;
    logic [16:0] sat_num;
    logic [16:0] sat_lim;
    logic        is_white;

    assign gray_acc = 22'(14'd4899 * red) + 22'(14'd9617 * green)
                    + 22'(11'd1868 * blue) + 22'd8192;
    assign gray     = gray_acc[21:14];
    assign mx_rg    = (red > green) ? red : green;
    assign vmax     = (blue > mx_rg) ? blue : mx_rg;
    assign mn_rg    = (red < green) ? red : green;
    assign vmin     = (blue < mn_rg) ? blue : mn_rg;
    // saturation below 80 is the same as num < 160 * v
    assign sat_num  = 17'(9'd510 * (vmax - vmin)) + 17'(vmax);
    assign sat_lim  = 17'(8'd160 * vmax);
    assign is_white = (vmax > 8'd160) && (sat_num < sat_lim);

    logic [12:0] bw_ext, bh_ext;
    assign bw_ext = {1'b0, box_width};
    assign bh_ext = {1'b0, box_height};

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.load_out) begin
            pix_cnt_reg    <= '0;
            edge_cnt_reg   <= '0;
            bright_cnt_reg <= '0;
            dark_cnt_reg   <= '0;
            white_cnt_reg  <= '0;
            gray_sum_reg   <= '0;
            gray_sq_reg    <= '0;
            held_w_reg     <= '0;
            held_h_reg     <= '0;
        end else if (cmd.acc) begin
            if (pix_cnt_reg == '0) begin
                held_w_reg <= (bw_ext > 13'(MAX_BOX_SIDE)) ? SIDE_W'(MAX_BOX_SIDE) : box_width;
                held_h_reg <= (bh_ext > 13'(MAX_BOX_SIDE)) ? SIDE_W'(MAX_BOX_SIDE) : box_height;
            end
            pix_cnt_reg <= pix_cnt_reg + CNT_W'(1);
            if (edge_value != 8'd0) edge_cnt_reg <= edge_cnt_reg + CNT_W'(1);
            if (gray > 8'd180)      bright_cnt_reg <= bright_cnt_reg + CNT_W'(1);
            if (gray < 8'd80)       dark_cnt_reg <= dark_cnt_reg + CNT_W'(1);
            if (is_white)           white_cnt_reg <= white_cnt_reg + CNT_W'(1);
            gray_sum_reg <= gray_sum_reg + SUM_W'(gray);
            gray_sq_reg  <= gray_sq_reg + SQSUM_W'(16'(gray * gray));
        end
    end

    // score preparation
    logic [23:0] area_reg;
    logic [25:0] fa_reg;
    logic [45:0] n2_reg;
    logic [59:0] b_reg;
    logic [41:0] pl_reg, ph_reg;
    logic [60:0] a_reg, d_reg;
    logic [13:0] diff_reg;
    logic [TERM_W-1:0] size_reg;
    logic [13:0] h4;

    assign h4 = {held_h_reg, 2'b00};

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            area_reg <= held_w_reg * held_h_reg;
            fa_reg   <= frame_width * frame_height;
            n2_reg   <= pix_cnt_reg * pix_cnt_reg;
            b_reg    <= gray_sum_reg * gray_sum_reg;
            // n times square sum, split in two halves of the square sum
            pl_reg   <= pix_cnt_reg * gray_sq_reg[18:0];
            ph_reg   <= pix_cnt_reg * gray_sq_reg[37:19];
        end
        if (cmd.prep1) begin
            a_reg    <= 61'(pl_reg) + (61'(ph_reg) << 19);
            diff_reg <= ({2'b00, held_w_reg} > h4) ? ({2'b00, held_w_reg} - h4)
                                                   : (h4 - {2'b00, held_w_reg});
            if (fa_reg == '0 || 33'(9'd500 * area_reg) < 33'(fa_reg)
                    || 29'(5'd25 * area_reg) > 29'({fa_reg, 1'b0}))
                size_reg <= '0;
            else
                size_reg <= ONE_T;
        end
        if (cmd.prep2) begin
            d_reg <= (a_reg > 61'(b_reg)) ? a_reg - 61'(b_reg) : '0;
        end
    end

    // shared divider
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [NUM_W-1:0] quot;
    logic             div_done;
    logic [CNT_W-1:0] min_bd;

    assign min_bd = (bright_cnt_reg < dark_cnt_reg) ? bright_cnt_reg : dark_cnt_reg;

    always_comb begin
        case (cmd.div_sel)
            DIV_ASPECT: begin
                div_num = (NUM_W'(diff_reg) << F) + NUM_W'({held_h_reg, 1'b0});
                div_den = DEN_W'(h4);
            end
            DIV_EDGE: begin
                div_num = (NUM_W'(edge_cnt_reg) << F) + NUM_W'(area_reg >> 1);
                div_den = DEN_W'(area_reg);
            end
            DIV_WHITE: begin
                div_num = (NUM_W'(white_cnt_reg) << F) + NUM_W'(area_reg >> 1);
                div_den = DEN_W'(area_reg);
            end
            DIV_LD: begin
                div_num = (NUM_W'({min_bd, 2'b00}) << F) + NUM_W'(area_reg >> 1);
                div_den = DEN_W'(area_reg);
            end
            DIV_CON: begin
                div_num = NUM_W'(d_reg) << K;
                div_den = n2_reg;
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    rpls_div #(
        .NUM_W(NUM_W),
        .DEN_W(DEN_W)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.div_start),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .quot   (quot)
    );

    logic [F:0] root;
    logic       sqrt_done;

    rpls_sqrt #(
        .F(F)
    ) u_sqrt (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.sqrt_start),
        .x_in   (quot[2*F-1:0]),
        .done   (sqrt_done),
        .root   (root)
    );

    assign status.div_done  = div_done;
    assign status.sqrt_done = sqrt_done;

    // score terms
    logic [TERM_W-1:0] aspect_reg, edge_reg, white_reg, ld_reg, con_reg;
    logic [TERM_W-1:0] ratio_q;
    logic              q_ge_one;
    logic              var_big;

    assign q_ge_one = quot >= NUM_W'(ONE_T);
    assign ratio_q  = (area_reg == '0) ? '0
                    : (quot > NUM_W'(ONE_T)) ? ONE_T : quot[TERM_W-1:0];
    assign var_big  = d_reg >= {1'b0, n2_reg, 14'b0};

    always_ff @(posedge aclk) begin
        if (cmd.div_cap) begin
            case (cmd.div_sel)
                DIV_ASPECT: aspect_reg <= (held_h_reg == '0 || q_ge_one) ? '0
                                        : ONE_T - quot[TERM_W-1:0];
                DIV_EDGE:   edge_reg  <= ratio_q;
                DIV_WHITE:  white_reg <= ratio_q;
                DIV_LD:     ld_reg    <= ratio_q;
                default:    ;
            endcase
        end
        if (cmd.sqrt_cap) begin
            con_reg <= (pix_cnt_reg == '0) ? '0 : var_big ? ONE_T : root;
        end
    end

    logic [TOT_W-1:0] total_reg;
    logic [15:0]      score_reg;

    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            total_reg <= (TOT_W'(aspect_reg) << 1) + TOT_W'(size_reg)
                       + TOT_W'(edge_reg) * TOT_W'(3) + (TOT_W'(con_reg) << 1)
                       + TOT_W'(ld_reg) * TOT_W'(3) + TOT_W'(white_reg);
        end
        if (cmd.load_out) begin
            score_reg <= (total_reg > TOT_W'(65535)) ? 16'hFFFF : total_reg[15:0];
        end
    end

    assign total_score = score_reg;

endmodule

`default_nettype wire

### design/rpls_ctrl.sv
// ----------------------------------------------------------------------------
// rpls_ctrl
// sequencer: pixel intake, score steps and result handshake
// ----------------------------------------------------------------------------
`default_nettype none

module rpls_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    input  wire logic                   s_last_pixel,
    output logic                        s_ready,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output rpls_pkg::rpls_cmd_t         cmd,
    input  wire rpls_pkg::rpls_status_t status
);

    import rpls_pkg::*;

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_MUL,
        ST_PREP1,
        ST_PREP2,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_SUM,
        ST_DONE
    } state_t;

    state_t   state_reg, state_next;
    logic     s_ready_reg, s_ready_next;
    logic     m_valid_reg, m_valid_next;
    div_sel_t sel_reg, sel_next;
    logic     load;

    assign load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        s_ready_next = s_ready_reg;
        m_valid_next = m_valid_reg;
        sel_next     = sel_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        case (state_reg)
            ST_ACCUM: begin
                if (s_valid && s_last_pixel) begin
                    s_ready_next = 1'b0;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_PREP1;
            ST_PREP1: state_next = ST_PREP2;
            ST_PREP2: begin
                sel_next   = DIV_ASPECT;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_DIV_GO;
                    case (sel_reg)
                        DIV_ASPECT: sel_next = DIV_EDGE;
                        DIV_EDGE:   sel_next = DIV_WHITE;
                        DIV_WHITE:  sel_next = DIV_LD;
                        DIV_LD:     sel_next = DIV_CON;
                        default:    state_next = ST_SQ_GO;
                    endcase
                end
            end
            ST_SQ_GO: state_next = ST_SQ_WAIT;
            ST_SQ_WAIT: begin
                if (status.sqrt_done) state_next = ST_SUM;
            end
            ST_SUM: state_next = ST_DONE;
            ST_DONE: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    s_ready_next = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default: state_next = ST_ACCUM;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCUM;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
            sel_reg     <= DIV_ASPECT;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
            sel_reg     <= sel_next;
        end
    end

    always_comb begin
        cmd            = '0;
        cmd.acc        = s_valid && s_ready_reg;
        cmd.mul        = state_reg == ST_MUL;
        cmd.prep1      = state_reg == ST_PREP1;
        cmd.prep2      = state_reg == ST_PREP2;
        cmd.div_start  = state_reg == ST_DIV_GO;
        cmd.div_sel    = sel_reg;
        cmd.div_cap    = (state_reg == ST_DIV_WAIT) && status.div_done;
        cmd.sqrt_start = state_reg == ST_SQ_GO;
        cmd.sqrt_cap   = (state_reg == ST_SQ_WAIT) && status.sqrt_done;
        cmd.sum        = state_reg == ST_SUM;
        cmd.load_out   = load;
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

### design/region_plate_likeness_score_top.sv
// ----------------------------------------------------------------------------
// region_plate_likeness_score_top
// plate likeness score of one candidate box, pixels in raster order
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while a box streams in. The word flagged
// last_pixel closes the box. The block then stops taking pixels for the
// scoring tail, which comes from the one-bit-per-cycle shared divider,
// which runs five divisions, and from the bit-serial square root. The tail
// runs longer while an earlier score is still waiting to be taken. The
// score waits in an output register, so the next box may stream in before
// it is taken. frame_width and frame_height sit at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
`default_nettype none

module region_plate_likeness_score_top #(
    parameter int MAX_BOX_SIDE  = rpls_pkg::RPLS_MAX_BOX_SIDE,
    parameter int FRACTION_BITS = rpls_pkg::RPLS_FRACTION_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_edge_value,
    input  wire logic [7:0]  s_red,
    input  wire logic [7:0]  s_green,
    input  wire logic [7:0]  s_blue,
    input  wire logic [11:0] s_box_width,
    input  wire logic [11:0] s_box_height,
    input  wire logic        s_last_pixel,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_total_score
);

    import rpls_pkg::*;

    logic [FRAME_W-1:0] fw_reg, fh_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= FRAME_W'(640);
            fh_reg <= FRAME_W'(480);
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) fh_reg <= pwdata[FRAME_W-1:0];
            else          fw_reg <= pwdata[FRAME_W-1:0];
        end
    end

    assign prdata = paddr[2] ? {19'b0, fh_reg} : {19'b0, fw_reg};

    rpls_cmd_t    cmd;
    rpls_status_t status;

    rpls_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_pixel(s_last_pixel),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .status      (status)
    );

    rpls_datapath #(
        .MAX_BOX_SIDE (MAX_BOX_SIDE),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .edge_value  (s_edge_value),
        .red         (s_red),
        .green       (s_green),
        .blue        (s_blue),
        .box_width   (s_box_width),
        .box_height  (s_box_height),
        .frame_width (fw_reg),
        .frame_height(fh_reg),
        .total_score (m_total_score)
    );

endmodule

`default_nettype wire

### tb/region_plate_likeness_score_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// region_plate_likeness_score_top_tb
// Streams candidate boxes of pixels into the plate likeness scorer and checks
// each score with an in-bench predictor of counters and six weighted terms or
// a fixed score, with random idling on both channels and several frame sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module region_plate_likeness_score_top_tb;
    import rpls_pkg::*;

    localparam int ONE_Q       = 1 << RPLS_FRACTION_BITS;
    localparam int REG_FRAME_W = 0;
    localparam int REG_FRAME_H = 1;
    localparam int TAIL_WAIT   = 700;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_edge_value = '0, s_red = '0, s_green = '0, s_blue = '0;
    logic [11:0] s_box_width = '0, s_box_height = '0;
    logic        s_last_pixel = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_total_score;

    region_plate_likeness_score_top dut (.*);

    always #6 aclk = ~aclk;

    // predictor state
    logic [12:0]        frame_w_q, frame_h_q;
    logic [CNT_W-1:0]   pix_cnt, edge_cnt, bright_cnt, dark_cnt, white_cnt;
    logic [SUM_W-1:0]   gray_acc;
    logic [SQSUM_W-1:0] gray_sq_acc;
    logic [11:0]        box_w_q, box_h_q;

    logic [15:0] score_q[$];
    int          errors = 0;
    bit          quiet = 0;
    int          ready_hold = 0;

    typedef struct {
        logic [7:0]  edge_v, r, g, b;
        logic [11:0] w, h;
        logic        last;
        int          score;
    } pixel_row_t;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic longint unsigned isqrt(input longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned frac_of_area(input longint unsigned c,
                                                     input longint unsigned a);
        longint unsigned q;
        if (a == 0) return 0;
        q = (c * ONE_Q + a / 2) / a;
        return (q > ONE_Q) ? ONE_Q : q;
    endfunction

    function automatic longint unsigned contrast_term();
        longint unsigned n, n2, d, a, b, q, r;
        n = pix_cnt;
        if (n == 0) return 0;
        n2 = n * n;
        a = n * gray_sq_acc;
        b = longint'(gray_acc) * gray_acc;
        d = (a > b) ? a - b : 0;
        if (d >= (n2 << 14)) return ONE_Q;
        q = d / n2;
        r = d % n2;
        for (int i = 0; i < 2 * RPLS_FRACTION_BITS - 14; i++) begin
            r <<= 1;
            q <<= 1;
            if (r >= n2) begin
                r -= n2;
                q |= 1;
            end
        end
        return isqrt(q);
    endfunction

    function automatic void clear_box();
        pix_cnt = 0; edge_cnt = 0; bright_cnt = 0; dark_cnt = 0; white_cnt = 0;
        gray_acc = 0; gray_sq_acc = 0; box_w_q = 0; box_h_q = 0;
    endfunction

    // advances the box accumulators; returns 1 with the score on a last pixel
    function automatic bit score_pixel(input pixel_row_t p, output logic [15:0] score);
        longint unsigned gray, vmax, vmin, sat, wd, ht, area, fa, diff, pen;
        longint unsigned aspect, size, total, mn;
        if (pix_cnt == 0) begin
            box_w_q = (p.w > RPLS_MAX_BOX_SIDE) ? 12'(RPLS_MAX_BOX_SIDE) : p.w;
            box_h_q = (p.h > RPLS_MAX_BOX_SIDE) ? 12'(RPLS_MAX_BOX_SIDE) : p.h;
        end
        gray = (4899 * p.r + 9617 * p.g + 1868 * p.b + 8192) >> 14;
        vmax = (p.r > p.g) ? p.r : p.g;
        if (p.b > vmax) vmax = p.b;
        vmin = (p.r < p.g) ? p.r : p.g;
        if (p.b < vmin) vmin = p.b;
        sat = (vmax == 0) ? 0 : (510 * (vmax - vmin) + vmax) / (2 * vmax);
        pix_cnt++;
        if (p.edge_v != 0) edge_cnt++;
        if (gray > 180) bright_cnt++;
        if (gray < 80) dark_cnt++;
        if (sat < 80 && vmax > 160) white_cnt++;
        gray_acc += SUM_W'(gray);
        gray_sq_acc += SQSUM_W'(gray * gray);
        score = '0;
        if (!p.last) return 0;
        wd = box_w_q;
        ht = box_h_q;
        area = wd * ht;
        aspect = 0;
        if (ht != 0) begin
            diff = (wd > 4 * ht) ? wd - 4 * ht : 4 * ht - wd;
            pen = (diff * ONE_Q + 2 * ht) / (4 * ht);
            aspect = (pen >= ONE_Q) ? 0 : ONE_Q - pen;
        end
        fa = longint'(frame_w_q) * frame_h_q;
        size = ONE_Q;
        if (fa == 0 || 500 * area < fa || 25 * area > 2 * fa) size = 0;
        mn = (bright_cnt < dark_cnt) ? bright_cnt : dark_cnt;
        total = 2 * aspect + size + 3 * frac_of_area(edge_cnt, area)
              + 2 * contrast_term() + 3 * frac_of_area(4 * mn, area)
              + frac_of_area(white_cnt, area);
        if (total > 65535) total = 65535;
        score = total[15:0];
        clear_box();
        return 1;
    endfunction

    task automatic send_pixel(input pixel_row_t p);
        logic [15:0] sc;
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_edge_value <= p.edge_v;
        s_red        <= p.r;
        s_green      <= p.g;
        s_blue       <= p.b;
        s_box_width  <= p.w;
        s_box_height <= p.h;
        s_last_pixel <= p.last;
        do @(posedge aclk); while (!s_ready);
        if (score_pixel(p, sc))
            score_q.push_back((p.score >= 0) ? 16'(p.score) : sc);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (score_q.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
    endtask

    task automatic apb_write(input int idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_FRAME_W) frame_w_q = data[12:0];
        else frame_h_q = data[12:0];
    endtask

    task automatic random_color(output logic [7:0] r, g, b);
        case ($urandom_range(0, 4))
            0: begin r = 8'($urandom_range(200, 255)); g = 8'($urandom_range(200, 255));
                     b = 8'($urandom_range(200, 255)); end
            1: begin r = 8'($urandom_range(0, 60)); g = 8'($urandom_range(0, 60));
                     b = 8'($urandom_range(0, 60)); end
            default: begin r = 8'($urandom); g = 8'($urandom); b = 8'($urandom); end
        endcase
    endtask

    // well-formed boxes of a few pixels, now and then a long one or odd sizes
    task automatic random_boxes(input int items);
        pixel_row_t p;
        int len, sent;
        logic [11:0] bw, bh;
        sent = 0;
        while (sent < items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            if ($urandom_range(0, 3) == 0) begin
                bw = 12'($urandom);
                bh = ($urandom_range(0, 7) == 0) ? 12'd0 : 12'($urandom);
            end else begin
                bh = 12'($urandom_range(8, 120));
                bw = 12'(4 * bh + $urandom_range(0, 40) - 20);
            end
            for (int i = 0; i < len; i++) begin
                p.edge_v = $urandom_range(0, 1) ? 8'($urandom) : 8'd0;
                random_color(p.r, p.g, p.b);
                // later pixels carry noise in the size fields, which is ignored
                p.w = (i == 0) ? bw : 12'($urandom);
                p.h = (i == 0) ? bh : 12'($urandom);
                p.last = (i == len - 1);
                p.score = -1;
                send_pixel(p);
                sent++;
            end
        end
    endtask

    pixel_row_t directed[] = '{
        '{8'h00, 8'd0,   8'd0,   8'd0,   12'd0,    12'd0,    1'b1, 0},
        '{8'h00, 8'd0,   8'd0,   8'd0,   12'd4,    12'd1,    1'b1, 8192},
        '{8'h00, 8'd0,   8'd0,   8'd0,   12'd4095, 12'd4095, 1'b1, 2048},
        '{8'hff, 8'd255, 8'd255, 8'd255, 12'd2048, 12'd2048, 1'b1, -1},
        '{8'hff, 8'd255, 8'd255, 8'd255, 12'd160,  12'd40,   1'b0, -1},
        '{8'h01, 8'd0,   8'd0,   8'd0,   12'd0,    12'd0,    1'b0, -1},
        '{8'h80, 8'd128, 8'd128, 8'd128, 12'd7,    12'd7,    1'b0, -1},
        '{8'h00, 8'd255, 8'd0,   8'd0,   12'd1,    12'd1,    1'b1, -1},
        '{8'h55, 8'd0,   8'd0,   8'd255, 12'd1,    12'd2048, 1'b1, -1},
        '{8'haa, 8'd255, 8'd255, 8'd0,   12'd100,  12'd25,   1'b0, -1},
        '{8'h00, 8'd0,   8'd255, 8'd255, 12'd0,    12'd0,    1'b0, -1},
        '{8'h0f, 8'd1,   8'd2,   8'd3,   12'd0,    12'd0,    1'b0, -1},
        '{8'hf0, 8'd240, 8'd250, 8'd245, 12'd0,    12'd0,    1'b1, -1},
        '{8'h00, 8'd10,  8'd20,  8'd30,  12'd2048, 12'd1,    1'b1, -1},
        '{8'hff, 8'd200, 8'd40,  8'd90,  12'd2047, 12'd512,  1'b1, -1}
    };

    always @(posedge aclk) begin
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_ready && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            ready_hold <= $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (score_q.size() == 0) report("unexpected word", m_total_score, -1);
            else begin
                if (m_total_score !== score_q[0])
                    report("total_score", m_total_score, score_q[0]);
                void'(score_q.pop_front());
            end
        end
    end

    initial begin
        frame_w_q = 13'd640;
        frame_h_q = 13'd480;
        clear_box();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i]) send_pixel(directed[i]);
        drain();
        apb_write(REG_FRAME_W, 32'd1);
        apb_write(REG_FRAME_H, 32'd1);
        random_boxes(150);
        drain();
        apb_write(REG_FRAME_W, 32'd4096);
        apb_write(REG_FRAME_H, 32'd4096);
        random_boxes(150);
        drain();
        apb_write(REG_FRAME_W, $urandom_range(1, 4096));
        apb_write(REG_FRAME_H, $urandom_range(1, 4096));
        random_boxes(150);
        drain();
        apb_write(REG_FRAME_W, 32'd640);
        apb_write(REG_FRAME_H, 32'd480);
        quiet = 1;
        random_boxes(180);
        drain();
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
